// ===== hdl/point_project_zbuffer_splat_defines.svh =====
// Assertion macros shared by the point splatter RTL.
`ifndef POINT_PROJECT_ZBUFFER_SPLAT_DEFINES_SVH
`define POINT_PROJECT_ZBUFFER_SPLAT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PZS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PZS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pzs_pkg.sv =====
// Types and constants for the point splatter.
package pzs_pkg;

  localparam int COEF_W = 16;
  localparam int VEC_W  = 17;
  localparam int PROD_W = 33;
  localparam int CLIP_W = 35;

  localparam logic [31:0] DEPTH_MAX = 32'h7FFF_FFFF;

  localparam logic [2:0] CFG_ROW0   = 3'd0;
  localparam logic [2:0] CFG_ROW1   = 3'd1;
  localparam logic [2:0] CFG_ROW2   = 3'd2;
  localparam logic [2:0] CFG_ROW3   = 3'd3;
  localparam logic [2:0] CFG_RADIUS = 3'd4;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;
  } pzs_in_t;

  typedef struct packed {
    logic [7:0] pixel_col;
    logic [7:0] pixel_row;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_write;
  } pzs_out_t;

  typedef enum logic [10:0] {
    S_CLR   = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_MUL   = 11'b000_0000_0100,
    S_WCHK  = 11'b000_0000_1000,
    S_NUM   = 11'b000_0001_0000,
    S_DIV   = 11'b000_0010_0000,
    S_AXIS  = 11'b000_0100_0000,
    S_SPLAT = 11'b000_1000_0000,
    S_PRD   = 11'b001_0000_0000,
    S_PCMP  = 11'b010_0000_0000,
    S_FLUSH = 11'b100_0000_0000
  } pzs_state_t;

endpackage

// ===== hdl/pzs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pzs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/point_project_zbuffer_splat.sv =====
// Top level of the z-buffered point splatter.
// One point is handled at a time. After reset a clearing pass writes the maximum depth
// to all IMAGE_WIDTH*IMAGE_HEIGHT depth entries, one per cycle, before the first request
// is taken. A point then passes through the shared 16x17 multiplier, forming the four
// clip coordinates, a sign check of w, and two restoring divisions (a setup step, 45
// quotient bits at one per cycle for a 256 by 256 image, a range check) for the screen
// column and row. Each splat pixel inside the image costs a depth read and then a
// compare-and-write on the single depth RAM; a pixel outside skips both. Results leave
// through an output register, and the sequencer waits only when its one-deep holding
// slot is full and that register is held by out_stall.
`include "point_project_zbuffer_splat_defines.svh"

module point_project_zbuffer_splat #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256,
  parameter int MAX_RADIUS   = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pzs_pkg::pzs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pzs_pkg::pzs_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [63:0]       cfg_data
);
  import pzs_pkg::*;

  localparam int MAXDIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int DIM_W  = $clog2(MAXDIM) + 1;
  localparam int CO_W   = $clog2(MAXDIM) + 2;
  localparam int NUM_W  = CLIP_W + DIM_W + 1;
  localparam int DCNT_W = $clog2(NUM_W);
  localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW     = $clog2(DEPTH);

  localparam logic signed [NUM_W-1:0] W_N  = NUM_W'(IMAGE_WIDTH);
  localparam logic signed [NUM_W-1:0] H_N  = NUM_W'(IMAGE_HEIGHT);
  localparam logic signed [NUM_W-1:0] WH_N = NUM_W'(IMAGE_WIDTH / 2);
  localparam logic signed [NUM_W-1:0] HH_N = NUM_W'(IMAGE_HEIGHT / 2);
  localparam logic signed [CO_W-1:0]  W_S  = CO_W'(IMAGE_WIDTH);
  localparam logic signed [CO_W-1:0]  H_S  = CO_W'(IMAGE_HEIGHT);
  localparam logic [2:0]              RMAX = 3'(MAX_RADIUS);

  pzs_state_t state_r, state_nxt;
  logic [63:0]              mat_r [4];
  logic [2:0]               rad_r;
  logic signed [VEC_W-1:0]  vec_r [3], vec_nxt [3];
  pzs_in_t                  pt_r, pt_nxt;
  logic [4:0]               cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [CLIP_W-1:0] acc_r [4], acc_nxt [4];
  logic                     axis_r, axis_nxt;
  logic [NUM_W-1:0]         mag_r, mag_nxt;
  logic [CLIP_W-1:0]        rem_r, rem_nxt;
  logic [CLIP_W-1:0]        dvs_r, dvs_nxt;
  logic                     neg_r, neg_nxt;
  logic [DCNT_W-1:0]        dcnt_r, dcnt_nxt;
  logic signed [CO_W-1:0]   sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [31:0]       depth_r, depth_nxt;
  logic signed [CO_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [CO_W-1:0]   x_hi_r, x_hi_nxt, y_lo_r, y_lo_nxt, y_hi_r, y_hi_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [AW-1:0]            clr_r, clr_nxt;
  logic                     pend_valid_r, pend_valid_nxt;
  pzs_out_t                 pend_r, pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  pzs_out_t                 out_r, out_nxt;

  logic signed [COEF_W-1:0] coef;
  logic signed [VEC_W-1:0]  vsel;
  logic [4:0]               cnt_m1;
  logic signed [NUM_W-1:0]  num;
  logic [CLIP_W:0]          trial, diff;
  logic                     ge;
  logic [2:0]               reff;
  logic signed [CO_W-1:0]   rs;
  logic signed [CO_W-1:0]   y_inc, x_inc;
  logic                     in_img;
  logic [AW-1:0]            pix_addr;
  logic                     pass, out_free, out_load;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr;
  logic [31:0]              mem_wdata, mem_rdata;
  logic                     axis_ok;
  logic                     adv_done;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Shared multiplier operand selection: row in cnt[3:2], column in cnt[1:0].
  always_comb begin
    coef = mat_r[cnt_r[3:2]][{cnt_r[1:0], 4'b0000} +: COEF_W];
    case (cnt_r[1:0])
      2'd0:    vsel = vec_r[0];
      2'd1:    vsel = vec_r[1];
      2'd2:    vsel = vec_r[2];
      default: vsel = VEC_W'(16);
    endcase
  end

  assign cnt_m1 = cnt_r - 5'd1;
  assign num = axis_r ? (NUM_W'(acc_r[1]) * H_N + HH_N * NUM_W'(acc_r[3]))
                      : (NUM_W'(acc_r[0]) * W_N + WH_N * NUM_W'(acc_r[3]));
  assign trial = {rem_r, mag_r[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign reff  = (rad_r > RMAX) ? RMAX : rad_r;
  assign rs    = CO_W'(reff);
  assign y_inc = y_r + CO_W'(1);
  assign x_inc = x_r + CO_W'(1);
  assign in_img = (x_r >= 0) && (x_r < W_S) && (y_r >= 0) && (y_r < H_S);
  assign pix_addr = AW'(AW'(y_r) * AW'(IMAGE_WIDTH)) + AW'(x_r);
  assign pass = ($signed(mem_rdata) > depth_r);
  assign axis_ok = (mag_r < NUM_W'(axis_r ? IMAGE_HEIGHT : IMAGE_WIDTH))
                   && (neg_r || (mag_r == '0));
  assign adv_done = (y_inc == y_hi_r) && (x_inc == x_hi_r);

  always_comb begin
    state_nxt      = state_r;
    vec_nxt        = vec_r;
    pt_nxt         = pt_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = PROD_W'(coef) * PROD_W'(vsel);
    acc_nxt        = acc_r;
    axis_nxt       = axis_r;
    mag_nxt        = mag_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    neg_nxt        = neg_r;
    dcnt_nxt       = dcnt_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    depth_nxt      = depth_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    x_hi_nxt       = x_hi_r;
    y_lo_nxt       = y_lo_r;
    y_hi_nxt       = y_hi_r;
    addr_nxt       = addr_r;
    clr_nxt        = clr_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    out_load       = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = 32'(depth_r);

    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = DEPTH_MAX;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          pt_nxt     = in_data;
          vec_nxt[0] = -VEC_W'(in_data.point_x);
          vec_nxt[1] = VEC_W'(in_data.point_y);
          vec_nxt[2] = VEC_W'(in_data.point_z);
          for (int i = 0; i < 4; i++) begin
            acc_nxt[i] = '0;
          end
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // The product of step k is registered in prod_r and added to the accumulator at step k+1.
        if (cnt_r != 5'd0) begin
          acc_nxt[cnt_m1[3:2]] = acc_r[cnt_m1[3:2]] + CLIP_W'(prod_r);
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd16) begin
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        if (!acc_r[3][CLIP_W-1]) begin
          state_nxt = S_IDLE;
        end else begin
          if (acc_r[2][CLIP_W-1:31] == '0 || acc_r[2][CLIP_W-1:31] == '1) begin
            depth_nxt = acc_r[2][31:0];
          end else if (acc_r[2][CLIP_W-1]) begin
            depth_nxt = 32'sh8000_0000;
          end else begin
            depth_nxt = 32'sh7FFF_FFFF;
          end
          axis_nxt  = 1'b0;
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        neg_nxt   = num[NUM_W-1];
        mag_nxt   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem_nxt   = '0;
        dvs_nxt   = CLIP_W'(-acc_r[3]);
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = ge ? diff[CLIP_W-1:0] : trial[CLIP_W-1:0];
        mag_nxt  = {mag_r[NUM_W-2:0], ge};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(NUM_W - 1)) begin
          state_nxt = S_AXIS;
        end
      end
      S_AXIS: begin
        // Quotient is positive only for a negative numerator, since w is negative.
        if (!axis_ok) begin
          state_nxt = S_IDLE;
        end else if (!axis_r) begin
          sx_nxt    = CO_W'(mag_r);
          axis_nxt  = 1'b1;
          state_nxt = S_NUM;
        end else begin
          sy_nxt    = CO_W'(mag_r);
          state_nxt = S_SPLAT;
        end
      end
      S_SPLAT: begin
        x_nxt     = sx_r - rs;
        x_hi_nxt  = (reff == 3'd0) ? sx_r + CO_W'(1) : sx_r + rs;
        y_nxt     = sy_r - rs;
        y_lo_nxt  = sy_r - rs;
        y_hi_nxt  = (reff == 3'd0) ? sy_r + CO_W'(1) : sy_r + rs;
        state_nxt = S_PRD;
      end
      S_PRD: begin
        if (in_img) begin
          mem_re    = 1'b1;
          addr_nxt  = pix_addr;
          state_nxt = S_PCMP;
        end else begin
          if (y_inc == y_hi_r) begin
            y_nxt = y_lo_r;
            x_nxt = x_inc;
          end else begin
            y_nxt = y_inc;
          end
          state_nxt = adv_done ? S_FLUSH : S_PRD;
        end
      end
      S_PCMP: begin
        if (!pass || !pend_valid_r || out_free) begin
          if (pass) begin
            mem_we = 1'b1;
            if (pend_valid_r) begin
              out_load = 1'b1;
              out_nxt  = pend_r;
            end
            pend_valid_nxt       = 1'b1;
            pend_nxt.pixel_col   = 8'(x_r);
            pend_nxt.pixel_row   = 8'(y_r);
            pend_nxt.out_red     = pt_r.color_red;
            pend_nxt.out_green   = pt_r.color_green;
            pend_nxt.out_blue    = pt_r.color_blue;
            pend_nxt.last_write  = 1'b0;
          end
          if (y_inc == y_hi_r) begin
            y_nxt = y_lo_r;
            x_nxt = x_inc;
          end else begin
            y_nxt = y_inc;
          end
          state_nxt = adv_done ? S_FLUSH : S_PRD;
        end
      end
      S_FLUSH: begin
        // The held result is the last one of this point.
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_load           = 1'b1;
          out_nxt            = pend_r;
          out_nxt.last_write = 1'b1;
          pend_valid_nxt     = 1'b0;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      rad_r        <= '0;
      for (int i = 0; i < 4; i++) begin
        mat_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ROW0:   mat_r[0] <= cfg_data;
          CFG_ROW1:   mat_r[1] <= cfg_data;
          CFG_ROW2:   mat_r[2] <= cfg_data;
          CFG_ROW3:   mat_r[3] <= cfg_data;
          CFG_RADIUS: rad_r    <= cfg_data[2:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    vec_r   <= vec_nxt;
    pt_r    <= pt_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    axis_r  <= axis_nxt;
    mag_r   <= mag_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_r   <= neg_nxt;
    dcnt_r  <= dcnt_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    depth_r <= depth_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    x_hi_r  <= x_hi_nxt;
    y_lo_r  <= y_lo_nxt;
    y_hi_r  <= y_hi_nxt;
    addr_r  <= addr_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  pzs_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_depth_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(pix_addr),
    .rdata(mem_rdata)
  );

  `PZS_ASSERT_SAME(a_we_state, mem_we, (state_r == S_CLR) || (state_r == S_PCMP), "depth write outside clear or compare")
  `PZS_ASSERT_NEXT(a_accept_mul, in_valid && !in_stall, state_r == S_MUL, "accepted request did not start multiply")
  `PZS_ASSERT_SAME(a_idle_no_pend, state_r == S_IDLE, !pend_valid_r, "held result left behind at idle")
  `PZS_ASSERT_SAME(a_load_free, out_load, out_free, "output register overwritten while stalled")

endmodule

// ===== dv/pzs_checker.sv =====
// Checker for the point splatter: predicts pixel writes and compares them with the block.
module pzs_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  pzs_pkg::pzs_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  pzs_pkg::pzs_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [63:0]       cfg_data,
  output int                errors,
  output int                pending,
  output int                checked
);
  import pzs_pkg::*;

  localparam int IMG_W = 256;
  localparam int IMG_H = 256;
  localparam int R_MAX = 4;

  logic [63:0] mat_row [4];
  logic [2:0]  radius;
  int          zbuf [IMG_W*IMG_H];
  pzs_out_t    pixel_q [$];

  initial begin
    for (int i = 0; i < IMG_W*IMG_H; i++) zbuf[i] = int'(DEPTH_MAX);
  end

  assign pending = pixel_q.size();

  // Depth test and write for one splat pixel; queues the color write when it passes.
  function automatic void splat_pixel(longint x, longint y, int d, pzs_in_t p,
                                      ref pzs_out_t wr [$]);
    int       idx;
    pzs_out_t o;
    if (x < 0 || x >= IMG_W || y < 0 || y >= IMG_H) return;
    idx = int'(y) * IMG_W + int'(x);
    if (!(zbuf[idx] > d)) return;
    zbuf[idx] = d;
    o.pixel_col   = 8'(x);
    o.pixel_row   = 8'(y);
    o.out_red     = p.color_red;
    o.out_green   = p.color_green;
    o.out_blue    = p.color_blue;
    o.last_write  = 1'b0;
    wr.push_back(o);
  endfunction

  function automatic void project_point(pzs_in_t p);
    longint             v [4];
    longint             clip [4];
    logic signed [15:0] k;
    longint             w, sx, sy, r;
    int                 d;
    pzs_out_t           wr [$];
    v[0] = -longint'(p.point_x);
    v[1] = longint'(p.point_y);
    v[2] = longint'(p.point_z);
    v[3] = 16;
    for (int i = 0; i < 4; i++) begin
      clip[i] = 0;
      for (int j = 0; j < 4; j++) begin
        k = mat_row[i][16*j +: 16];
        clip[i] += longint'(k) * v[j];
      end
    end
    w = clip[3];
    if (w >= 0) return;
    if (clip[2] > 64'sd2147483647) d = 32'h7FFF_FFFF;
    else if (clip[2] < -64'sd2147483648) d = 32'h8000_0000;
    else d = int'(clip[2]);
    sx = (clip[0] * IMG_W + (IMG_W/2) * w) / w;
    sy = (clip[1] * IMG_H + (IMG_H/2) * w) / w;
    if (sx < 0 || sx >= IMG_W || sy < 0 || sy >= IMG_H) return;
    r = (radius > R_MAX) ? R_MAX : radius;
    if (r == 0) splat_pixel(sx, sy, d, p, wr);
    else begin
      for (longint x = sx - r; x < sx + r; x++)
        for (longint y = sy - r; y < sy + r; y++)
          splat_pixel(x, y, d, p, wr);
    end
    if (wr.size() > 0) wr[wr.size()-1].last_write = 1'b1;
    foreach (wr[i]) pixel_q.push_back(wr[i]);
  endfunction

  always @(posedge clk) begin
    pzs_out_t e;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) mat_row[i] <= '0;
      radius <= '0;
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ROW0:   mat_row[0] <= cfg_data;
          CFG_ROW1:   mat_row[1] <= cfg_data;
          CFG_ROW2:   mat_row[2] <= cfg_data;
          CFG_ROW3:   mat_row[3] <= cfg_data;
          CFG_RADIUS: radius     <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) project_point(in_data);
      if (out_valid && !out_stall) begin
        checked++;
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel write, expected none, actual %p", $time, out_data);
        end else begin
          e = pixel_q.pop_front();
          if (e !== out_data) begin
            errors++;
            $display("%0t: pixel write mismatch, expected %p, actual %p", $time, e, out_data);
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb.sv =====
// Testbench top for the point splatter: stimulus, configuration phases and verdict.
module tb;
  import pzs_pkg::*;

  localparam int LIMIT = 1_500_000;
  localparam int DRAIN = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pzs_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pzs_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = CFG_ROW0;
  logic [63:0] cfg_data = '0;
  int          errors, pending, checked;
  int          cycles = 0;
  int          sent = 0;
  bit          quiet = 1'b0;

  always #5 clk = ~clk;

  point_project_zbuffer_splat dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_addr, .cfg_data
  );

  pzs_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_addr, .cfg_data, .errors, .pending, .checked
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 10);
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [63:0] mat_row(int c0, int c1, int c2, int c3);
    return {16'(c3), 16'(c2), 16'(c1), 16'(c0)};
  endfunction

  function automatic pzs_in_t make_point(int x, int y, int z, int r, int g, int b);
    pzs_in_t p;
    p.point_x = 16'(x);
    p.point_y = 16'(y);
    p.point_z = 16'(z);
    p.color_red = 8'(r);
    p.color_green = 8'(g);
    p.color_blue = 8'(b);
    return p;
  endfunction

  // Valid stays high across back-to-back requests; it only drops for an idle gap.
  task automatic send_point(pzs_in_t p);
    while (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Valid is dropped and the clock advances first, so the last accepted request is seen by the checker and the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // All five registers are written on consecutive cycles.
  task automatic load_setup(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                            logic [63:0] r3, logic [2:0] rad);
    logic [63:0] vals [5];
    vals = '{r0, r1, r2, r3, 64'(rad)};
    for (int i = 0; i < 5; i++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic pzs_in_t random_point();
    if ($urandom_range(99) < 15)
      return make_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    return make_point($urandom_range(255) - 128, $urandom_range(255) - 128,
                      $urandom_range(4000) - 2000, $urandom, $urandom, $urandom);
  endfunction

  initial begin
    logic [2:0] radii [8];
    int         sgn;
    radii = '{3'd1, 3'd2, 3'd0, 3'd3, 3'd4, 3'd5, 3'd7, 3'd4};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Depth saturation: screen center always, depth from a huge row.
    load_setup(64'h0, 64'h0, mat_row(32767, 32767, 32767, 32767),
               mat_row(0, 0, 0, -4096), 3'd0);
    send_point(make_point(-32768, 32767, 32767, 255, 255, 255));
    send_point(make_point(32767, -32768, -32768, 0, 0, 0));
    send_point(make_point(32767, -32768, -32768, 1, 2, 3));
    send_point(make_point(0, 0, 0, 170, 85, 170));
    wait_idle();

    // Unit-scale projection with radius 4: edges, corners, off screen and positive w.
    load_setup(mat_row(256, 0, 0, 0), mat_row(0, 256, 0, 0), mat_row(0, 0, 4096, 0),
               mat_row(0, 0, 16, -4096), 3'd4);
    send_point(make_point(-128, -128, 100, 255, 0, 255));
    send_point(make_point(127, 127, 100, 0, 255, 0));
    send_point(make_point(-128, 127, -100, 85, 170, 85));
    send_point(make_point(127, -128, -100, 255, 255, 0));
    send_point(make_point(0, 0, 50, 1, 1, 1));
    send_point(make_point(2, 2, 60, 2, 2, 2));
    send_point(make_point(1, 1, 10, 3, 3, 3));
    send_point(make_point(200, 0, 0, 4, 4, 4));
    send_point(make_point(0, -200, 0, 5, 5, 5));
    send_point(make_point(0, 0, 4096, 6, 6, 6));
    send_point(make_point(0, 0, 32767, 7, 7, 7));
    send_point(make_point(-32768, 0, -32768, 8, 8, 8));
    send_point(make_point(32767, 32767, 0, 9, 9, 9));
    wait_idle();

    load_setup(64'h0, 64'h0, 64'h0, 64'h0, 3'd7);
    send_point(make_point(10, 10, 10, 10, 10, 10));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      sgn = $urandom_range(1) ? 1 : -1;
      if (ph == 6)
        load_setup('1, '1, '1, '1, radii[ph]);
      else
        load_setup(mat_row(sgn * $urandom_range(300, 200), $urandom_range(32) - 16, 0, 0),
                   mat_row($urandom_range(32) - 16, $urandom_range(300, 200), 0, 0),
                   mat_row($urandom_range(64) - 32, 0, sgn * 4096, $urandom_range(64) - 32),
                   mat_row(0, $urandom_range(8), 16, -4096), radii[ph]);
      quiet = (ph == 2);
      for (int i = 0; i < 37; i++) begin
        if (ph == 3 && i == 18) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_point(random_point());
      end
      quiet = 1'b0;
      wait_idle();
    end

    $display("Sent %0d points over eleven register setups (radius 0 to 7, saturated depth,",
             sent);
    $display("off-screen and positive-w points); %0d pixel writes checked.", checked);
    if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== point_project_zbuffer_splat.f =====
+incdir+hdl
hdl/pzs_pkg.sv
hdl/pzs_ram.sv
hdl/point_project_zbuffer_splat.sv
dv/pzs_checker.sv
dv/tb.sv
